[sv/kbtt_pkg.sv]
// kbtt_pkg: command codes, result word layout and reset constants
// for the keyboard typematic translator
// no dependencies
package kbtt_pkg;

	// command codes carried in s_tuser
	typedef enum logic [2:0] {
		CMD_SCAN       = 3'd0,
		CMD_POP        = 3'd1,
		CMD_FLUSH      = 3'd2,
		CMD_TABLE_WR   = 3'd3,
		CMD_DISCONNECT = 3'd4
	} cmd_t;

	// result word, char_valid in the lowest bit
	typedef struct packed {
		logic        ready_res;
		logic        key_pending;
		logic [15:0] char_code;
		logic        char_valid;
	} res_t;

	localparam int unsigned RES_W     = 19;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned IN_DATA_W  = 88;

	// register byte addresses, bit 2 picks the register
	localparam logic ADDR_REPEAT_DELAY = 1'b0;
	localparam logic ADDR_REPEAT_RATE  = 1'b1;

	localparam logic [7:0] REPEAT_DELAY_RST = 8'd20;
	localparam logic [7:0] REPEAT_RATE_RST  = 8'd5;
	localparam logic [7:0] LAST_KEY_RST     = 8'hFF;
	localparam logic [7:0] COUNT_MAX        = 8'hFF;
	localparam logic [7:0] MOD_HIGH_MASK    = 8'hF8;
	localparam logic [7:0] MIN_REAL_KEY     = 8'd2;
	localparam int unsigned SHIFT_BIT       = 5;

endpackage

[sv/keyboard_typematic_translator.sv]
// keyboard_typematic_translator: scan report decoding, typematic repeat,
// table translation and character ring buffer
// depends on kbtt_pkg
//
// usage
// - input words arrive on s_tvalid/s_tready with the command in s_tuser and the
//   report, table write address and table byte in s_tdata
// - every input word gives exactly one result word on m_tvalid/m_tready:
//   pop flag, popped character, pending flag and ready status
// - a word is taken every cycle while the output queue has room; the result is
//   registered in stage 1 and then in the output queue before it is offered, and
//   is taken when the receiver is ready
// - key table (512 x 8) and character ring (FIFO_DEPTH x 16) are synchronous
//   memories with registered reads; the table is read at acceptance, the ring
//   entry is written in the cycle after acceptance and a pop that hits that entry
//   is forwarded from the pending write
// - a stalled receiver fills a four-word output queue, after which s_tready
//   drops; no word is lost
// - reset clears pointers and the output queue and returns the repeat state to its
//   reset values; the key table and ring contents are undefined until written
// - repeat_delay and repeat_rate sit behind an APB port at byte 0 and 4
module keyboard_typematic_translator #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot0..slot5 [47:0], modifiers [55:48], language [63:56],
	// table_index [72:64], table_char [80:73], zero pad [87:81]
	input  logic [kbtt_pkg::IN_DATA_W-1:0] s_tdata,
	// cmd [2:0]
	input  logic [2:0]  s_tuser,
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// char_valid [0], char_code [16:1], key_pending [17], ready_res [18],
	// zero pad [23:19]
	output logic [kbtt_pkg::OUT_DATA_W-1:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);
	localparam int unsigned OQ_DEPTH = 4;

	// configuration registers
	logic [7:0] repeat_delay_q, repeat_rate_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q <= kbtt_pkg::REPEAT_DELAY_RST;
			repeat_rate_q  <= kbtt_pkg::REPEAT_RATE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == kbtt_pkg::ADDR_REPEAT_DELAY) repeat_delay_q <= pwdata[7:0];
			else repeat_rate_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == kbtt_pkg::ADDR_REPEAT_RATE) ? {24'd0, repeat_rate_q}
	                                                          : {24'd0, repeat_delay_q};

	// input fields
	kbtt_pkg::cmd_t cmd;
	logic [7:0]     slot [6];
	logic [7:0]     modifiers, language, table_char;
	logic [8:0]     table_index;
	logic           acc;

	assign cmd = kbtt_pkg::cmd_t'(s_tuser);
	always_comb begin
		for (int i = 0; i < 6; i++) slot[i] = s_tdata[8*i +: 8];
	end
	assign modifiers   = s_tdata[55:48];
	assign language    = s_tdata[63:56];
	assign table_index = s_tdata[72:64];
	assign table_char  = s_tdata[80:73];
	assign acc         = s_tvalid & s_tready;

	// control state
	logic [IW-1:0] rd_idx_q, wr_idx_q;
	logic [7:0]    last_key_q, delay_q, rate_q;
	logic          repeating_q, ready_q;

	// stage 1 registers
	logic          valid_s1, push_s1, pop_s1, fwd_s1;
	logic [IW-1:0] push_addr_s1;
	logic [7:0]    push_mod_s1;
	logic [7:0]    table_rdata_s1;
	logic [15:0]   fifo_rdata_s1, fwd_data_s1;
	logic          pending_s1, ready_s1;

	// key table and character ring
	logic [7:0]  key_table_q [512];
	logic [15:0] char_fifo_q [FIFO_DEPTH];
	logic [15:0] push_word;

	// next-state logic for the accepted word
	logic [7:0]    key, mods_m, nxt_last, nxt_delay, nxt_rate;
	logic          key_found, full, emit, nxt_rep, nxt_ready, do_pop;
	logic [IW-1:0] nxt_rd, nxt_wr, wr_inc, rd_inc;

	assign wr_inc = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_inc = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign full   = (wr_inc == rd_idx_q);

	// lowest slot holding a real key
	always_comb begin
		key       = '0;
		key_found = 1'b0;
		for (int i = 5; i >= 0; i--) begin
			if (slot[i] >= kbtt_pkg::MIN_REAL_KEY) begin
				key       = slot[i];
				key_found = 1'b1;
			end
		end
	end

	assign mods_m = (modifiers & kbtt_pkg::MOD_HIGH_MASK) | {1'b0, modifiers[2:0], 4'd0};

	always_comb begin
		nxt_last  = last_key_q;
		nxt_delay = delay_q;
		nxt_rate  = rate_q;
		nxt_rep   = repeating_q;
		nxt_ready = ready_q;
		nxt_rd    = rd_idx_q;
		nxt_wr    = wr_idx_q;
		emit      = 1'b0;
		do_pop    = 1'b0;
		unique case (cmd)
			kbtt_pkg::CMD_SCAN: begin
				if (ready_q || language != 8'd0) begin
					nxt_ready = 1'b1;
					if (!key_found) begin
						nxt_delay = '0;
						nxt_rep   = 1'b0;
						nxt_last  = '0;
					end else if (!full) begin
						// held key counts towards repeat, a new key goes out at once
						if (key == last_key_q) begin
							if (delay_q != kbtt_pkg::COUNT_MAX) nxt_delay = delay_q + 8'd1;
							if (nxt_delay > repeat_delay_q) nxt_rep = 1'b1;
						end else begin
							nxt_delay = '0;
							nxt_rep   = 1'b0;
							emit      = 1'b1;
						end
						if (nxt_rep) begin
							if (rate_q != kbtt_pkg::COUNT_MAX) nxt_rate = rate_q + 8'd1;
							if (nxt_rate >= repeat_rate_q) begin
								emit     = 1'b1;
								nxt_rate = '0;
							end
						end else begin
							nxt_rate = '0;
						end
						if (emit) begin
							nxt_wr   = wr_inc;
							nxt_last = key;
						end
					end
				end
			end
			kbtt_pkg::CMD_POP: begin
				if (rd_idx_q != wr_idx_q) begin
					do_pop = 1'b1;
					nxt_rd = rd_inc;
				end
			end
			kbtt_pkg::CMD_FLUSH: begin
				nxt_rd = '0;
				nxt_wr = '0;
			end
			kbtt_pkg::CMD_DISCONNECT: nxt_ready = 1'b0;
			default: ;
		endcase
	end

	// control state update at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			last_key_q  <= kbtt_pkg::LAST_KEY_RST;
			delay_q     <= '0;
			rate_q      <= '0;
			repeating_q <= 1'b1;
			ready_q     <= 1'b0;
		end else if (acc) begin
			rd_idx_q    <= nxt_rd;
			wr_idx_q    <= nxt_wr;
			last_key_q  <= nxt_last;
			delay_q     <= nxt_delay;
			rate_q      <= nxt_rate;
			repeating_q <= nxt_rep;
			ready_q     <= nxt_ready;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			push_s1  <= 1'b0;
			pop_s1   <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			push_s1  <= acc & emit;
			pop_s1   <= acc & do_pop;
			// ring write of the previous word lands at this edge: forward it
			fwd_s1   <= acc & do_pop & push_s1 & (push_addr_s1 == rd_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			push_addr_s1 <= wr_idx_q;
			push_mod_s1  <= mods_m;
			pending_s1   <= (nxt_rd != nxt_wr);
			ready_s1     <= nxt_ready;
		end
		fwd_data_s1 <= push_word;
	end

	// key table: written by table words, read for every accepted word
	always_ff @(posedge clk) begin
		if (acc && cmd == kbtt_pkg::CMD_TABLE_WR) key_table_q[table_index] <= table_char;
		if (acc) table_rdata_s1 <= key_table_q[{mods_m[kbtt_pkg::SHIFT_BIT], key}];
	end

	// character ring: read at acceptance, written from stage 1
	assign push_word = {push_mod_s1, table_rdata_s1};

	always_ff @(posedge clk) begin
		if (push_s1) char_fifo_q[push_addr_s1] <= push_word;
		if (acc) fifo_rdata_s1 <= char_fifo_q[rd_idx_q];
	end

	// result word of stage 1
	kbtt_pkg::res_t res_s1;
	always_comb begin
		res_s1.char_valid  = pop_s1;
		res_s1.char_code   = pop_s1 ? (fwd_s1 ? fwd_data_s1 : fifo_rdata_s1) : 16'd0;
		res_s1.key_pending = pending_s1;
		res_s1.ready_res   = ready_s1;
	end

	// output queue
	kbtt_pkg::res_t oq_data_q [OQ_DEPTH];
	logic [1:0]     oq_wr_q, oq_rd_q;
	logic [2:0]     oq_cnt_q;
	logic           oq_pop;

	assign m_tvalid = (oq_cnt_q != 3'd0);
	assign oq_pop   = m_tvalid & m_tready;
	assign m_tdata  = {{(kbtt_pkg::OUT_DATA_W - kbtt_pkg::RES_W){1'b0}}, oq_data_q[oq_rd_q]};
	assign s_tready = ({1'b0, oq_cnt_q} + {3'b000, valid_s1}) < 4'(OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (valid_s1) oq_data_q[oq_wr_q] <= res_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) oq_wr_q <= oq_wr_q + 2'd1;
			if (oq_pop) oq_rd_q <= oq_rd_q + 2'd1;
			oq_cnt_q <= oq_cnt_q + {2'b00, valid_s1} - {2'b00, oq_pop};
		end
	end

	// checks
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, oq_cnt_q} + {3'b000, valid_s1}) <= 4'(OQ_DEPTH))
		else $error("output queue overrun");

	a_push_pending: assert property (@(posedge clk) disable iff (!arst_n)
		push_s1 |-> res_s1.key_pending)
		else $error("push left the ring empty");

	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(acc && cmd == kbtt_pkg::CMD_SCAN && language != 8'd0))
		else $error("ready set without a report carrying a layout");

	a_fwd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> pop_s1 && $past(push_s1))
		else $error("forward without a pending ring write");

endmodule
